FILE: rtl/core/gcca_pkg.sv
// ----------------------------------------------------------------------------
// gcca_pkg
// shared widths, angle constants, arctangent table and fixed-point helpers
// for the great circle central angle pipeline
// ----------------------------------------------------------------------------
package gcca_pkg;

    localparam int ANGLE_BITS    = 32;
    localparam int FRACTION_BITS = 28;

    // internal formats: 30 fraction bits
    localparam int WFB      = 30;
    localparam int STEPS    = 30;
    localparam int SQ_STEPS = 32;
    localparam int AW       = 34;
    localparam int VW       = 36;
    localparam int SQW      = 64;
    localparam int OUT_W    = FRACTION_BITS + 2;

    localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;

    // 2*pi at the input format, rounded to nearest
    localparam logic [63:0] FULL =
        (PI_Q61 + (64'd1 << (59 - FRACTION_BITS))) >> (60 - FRACTION_BITS);
    // pi at the output format, rounded to nearest
    localparam logic [63:0] PIF =
        (PI_Q61 + (64'd1 << (60 - FRACTION_BITS))) >> (61 - FRACTION_BITS);

    // FULL << RED_J covers the whole input range
    localparam int RED_J = $clog2(((64'd1 << ANGLE_BITS) + FULL - 64'd1) / FULL);

    localparam int RED_RSH = (FRACTION_BITS > WFB) ? (FRACTION_BITS - WFB) : 0;
    localparam int RED_LSH = (FRACTION_BITS < WFB) ? (WFB - FRACTION_BITS) : 0;
    localparam int OUT_RSH = (WFB > FRACTION_BITS) ? (WFB - FRACTION_BITS) : 0;
    localparam int OUT_LSH = (WFB < FRACTION_BITS) ? (FRACTION_BITS - WFB) : 0;

    localparam logic signed [AW-1:0] PI_W      = 34'sd3373259426;
    localparam logic signed [AW-1:0] HALF_PI_W = 34'sd1686629713;
    localparam logic signed [AW-1:0] TWO_PI_W  = 34'sd6746518852;
    localparam logic signed [AW-1:0] GAIN_W    = 34'sd652032874;

    localparam logic signed [AW-1:0] ARC_TAB [STEPS] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128,
        34'sd64,        34'sd32,        34'sd16,        34'sd8,
        34'sd4,         34'sd2
    };

    typedef struct packed {
        logic valid;
        logic zero;
    } ctl_t;

    // wrap into [-pi, pi) at 30 fraction bits
    function automatic logic signed [AW-1:0] reduce_angle(
        input logic signed [ANGLE_BITS:0] a
    );
        logic [63:0]        v;
        logic signed [63:0] r;
        v = 64'(a) + (FULL << RED_J);
        for (int j = RED_J; j >= 0; j--)
        begin
            if (v >= (FULL << j))
            begin
                v = v - (FULL << j);
            end
        end
        r = ((signed'(v) <<< RED_LSH) + ((64'sd1 <<< RED_RSH) >>> 1)) >>> RED_RSH;
        if (r >= 64'(PI_W))
        begin
            r = r - 64'(TWO_PI_W);
        end
        return r[AW-1:0];
    endfunction

    // product at 30 fraction bits, rounded half away from zero
    function automatic logic signed [AW-1:0] mulw(
        input logic signed [AW-1:0] a,
        input logic signed [AW-1:0] b
    );
        logic signed [2*AW-1:0] p;
        logic [2*AW-1:0]        m;
        logic signed [AW-1:0]   r;
        p = a * b;
        m = p[2*AW-1] ? unsigned'(-p) : unsigned'(p);
        m = (m + ((2*AW)'(1) << (WFB - 1))) >> WFB;
        r = m[AW-1:0];
        return p[2*AW-1] ? -r : r;
    endfunction

endpackage

FILE: rtl/core/gcca_rot_cell.sv
// ----------------------------------------------------------------------------
// gcca_rot_cell
// one rotation step of the sine/cosine chain, registered
// ----------------------------------------------------------------------------
module gcca_rot_cell (
    input  logic                              clk,
    input  logic                              en,
    input  logic [4:0]                        step,
    input  logic signed [gcca_pkg::AW-1:0]    arc,
    input  logic signed [gcca_pkg::AW-1:0]    x_in,
    input  logic signed [gcca_pkg::AW-1:0]    y_in,
    input  logic signed [gcca_pkg::AW-1:0]    z_in,
    output logic signed [gcca_pkg::AW-1:0]    x_out,
    output logic signed [gcca_pkg::AW-1:0]    y_out,
    output logic signed [gcca_pkg::AW-1:0]    z_out
);

    logic signed [gcca_pkg::AW-1:0] x_reg, y_reg, z_reg;
    logic signed [gcca_pkg::AW-1:0] x_next, y_next, z_next;

    always_comb
    begin
        if (z_in >= 0)
        begin
            x_next = x_in - (y_in >>> step);
            y_next = y_in + (x_in >>> step);
            z_next = z_in - arc;
        end
        else
        begin
            x_next = x_in + (y_in >>> step);
            y_next = y_in - (x_in >>> step);
            z_next = z_in + arc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

FILE: rtl/core/gcca_sqrt_cell.sv
// ----------------------------------------------------------------------------
// gcca_sqrt_cell
// one result bit of the digit-by-digit integer square root, registered
// ----------------------------------------------------------------------------
module gcca_sqrt_cell (
    input  logic                          clk,
    input  logic                          en,
    input  logic [4:0]                    step,
    input  logic [gcca_pkg::SQW-1:0]      v_in,
    input  logic [gcca_pkg::SQW-1:0]      res_in,
    output logic [gcca_pkg::SQW-1:0]      v_out,
    output logic [gcca_pkg::SQW-1:0]      res_out
);

    logic [gcca_pkg::SQW-1:0] v_reg, res_reg;
    logic [gcca_pkg::SQW-1:0] v_next, res_next;
    logic [gcca_pkg::SQW-1:0] bitv, trial;

    always_comb
    begin
        bitv  = gcca_pkg::SQW'(1) << (7'd62 - 7'({step, 1'b0}));
        trial = res_in + bitv;
        if (v_in >= trial)
        begin
            v_next   = v_in - trial;
            res_next = (res_in >> 1) + bitv;
        end
        else
        begin
            v_next   = v_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg   <= v_next;
            res_reg <= res_next;
        end
    end

    assign v_out   = v_reg;
    assign res_out = res_reg;

endmodule

FILE: rtl/core/gcca_vec_cell.sv
// ----------------------------------------------------------------------------
// gcca_vec_cell
// one vectoring step of the arctangent chain, registered
// ----------------------------------------------------------------------------
module gcca_vec_cell (
    input  logic                              clk,
    input  logic                              en,
    input  logic [4:0]                        step,
    input  logic signed [gcca_pkg::AW-1:0]    arc,
    input  logic signed [gcca_pkg::VW-1:0]    x_in,
    input  logic signed [gcca_pkg::VW-1:0]    y_in,
    input  logic signed [gcca_pkg::AW-1:0]    z_in,
    output logic signed [gcca_pkg::VW-1:0]    x_out,
    output logic signed [gcca_pkg::VW-1:0]    y_out,
    output logic signed [gcca_pkg::AW-1:0]    z_out
);

    logic signed [gcca_pkg::VW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [gcca_pkg::AW-1:0] z_reg, z_next;

    always_comb
    begin
        if (y_in > 0)
        begin
            x_next = x_in + (y_in >>> step);
            y_next = y_in - (x_in >>> step);
            z_next = z_in + arc;
        end
        else
        begin
            x_next = x_in - (y_in >>> step);
            y_next = y_in + (x_in >>> step);
            z_next = z_in - arc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

FILE: rtl/core/great_circle_central_angle_top.sv
// ----------------------------------------------------------------------------
// great_circle_central_angle_top
// pipelined central angle between two sphere points (Vincenty formula)
//
//   channel  handshake            payload
//   input    in_valid / in_ready  colat_a, lon_a, colat_b, lon_b
//   output   out_valid/out_ready  central_angle
//
// one item per cycle while no result waits; built from three 30-cell rotation
// chains, the 32-cell square root chain and the 30-cell vectoring chain
// every stage advances together; a waiting result stops the whole pipe,
// and the input is taken whenever the last stage is empty or being read
// reset clears only the control line, the stage valid and zero flags
// ----------------------------------------------------------------------------
module great_circle_central_angle_top (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic signed [gcca_pkg::ANGLE_BITS-1:0]      colat_a,
    input  logic signed [gcca_pkg::ANGLE_BITS-1:0]      lon_a,
    input  logic signed [gcca_pkg::ANGLE_BITS-1:0]      colat_b,
    input  logic signed [gcca_pkg::ANGLE_BITS-1:0]      lon_b,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [gcca_pkg::OUT_W-1:0]                  central_angle
);

    localparam int AW    = gcca_pkg::AW;
    localparam int VW    = gcca_pkg::VW;
    localparam int SQW   = gcca_pkg::SQW;
    localparam int STEPS = gcca_pkg::STEPS;
    localparam int SQS   = gcca_pkg::SQ_STEPS;

    localparam int ST_F  = 1;
    localparam int ST_N  = ST_F + STEPS + 1;
    localparam int ST_S  = ST_N + 5;
    localparam int ST_P  = ST_S + SQS + 1;
    localparam int ST_O  = ST_P + STEPS + 1;
    localparam int LAT   = ST_O + 1;

    logic en;
    gcca_pkg::ctl_t ctl_line [LAT];
    gcca_pkg::ctl_t ctl_next [LAT];

    assign en        = !ctl_line[LAT-1].valid || out_ready;
    assign in_ready  = en;
    assign out_valid = ctl_line[LAT-1].valid;

    // stage 0: wrap the angles
    logic signed [AW-1:0] t1_reg, t2_reg, dp_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg <= gcca_pkg::reduce_angle((gcca_pkg::ANGLE_BITS+1)'(colat_a));
            t2_reg <= gcca_pkg::reduce_angle((gcca_pkg::ANGLE_BITS+1)'(colat_b));
            dp_reg <= gcca_pkg::reduce_angle((gcca_pkg::ANGLE_BITS+1)'(lon_b)
                                             - (gcca_pkg::ANGLE_BITS+1)'(lon_a));
        end
    end

    // stage 1: fold into [-pi/2, pi/2], lanes are t1, t2, dp
    logic signed [AW-1:0] ang [3];
    logic signed [AW-1:0] fz_reg [3];
    logic                 fneg_reg [3];

    assign ang[0] = t1_reg;
    assign ang[1] = t2_reg;
    assign ang[2] = dp_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int g = 0; g < 3; g++)
            begin
                if (ang[g] > gcca_pkg::HALF_PI_W)
                begin
                    fz_reg[g]   <= ang[g] - gcca_pkg::PI_W;
                    fneg_reg[g] <= 1'b1;
                end
                else if (ang[g] < -gcca_pkg::HALF_PI_W)
                begin
                    fz_reg[g]   <= ang[g] + gcca_pkg::PI_W;
                    fneg_reg[g] <= 1'b1;
                end
                else
                begin
                    fz_reg[g]   <= ang[g];
                    fneg_reg[g] <= 1'b0;
                end
            end
        end
    end

    // rotation chains
    logic signed [AW-1:0] rx [3][STEPS+1];
    logic signed [AW-1:0] ry [3][STEPS+1];
    logic signed [AW-1:0] rz [3][STEPS+1];
    logic                 rneg [3][STEPS+1];

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        assign rx[g][0]   = gcca_pkg::GAIN_W;
        assign ry[g][0]   = '0;
        assign rz[g][0]   = fz_reg[g];
        assign rneg[g][0] = fneg_reg[g];
        for (genvar i = 0; i < STEPS; i++)
        begin : g_cell
            gcca_rot_cell u_cell (
                .clk   (clk),
                .en    (en),
                .step  (5'(i)),
                .arc   (gcca_pkg::ARC_TAB[i]),
                .x_in  (rx[g][i]),
                .y_in  (ry[g][i]),
                .z_in  (rz[g][i]),
                .x_out (rx[g][i+1]),
                .y_out (ry[g][i+1]),
                .z_out (rz[g][i+1])
            );
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rneg[g][i+1] <= rneg[g][i];
                end
            end
        end
    end

    // stage N: undo the fold
    logic signed [AW-1:0] sn_reg [3];
    logic signed [AW-1:0] cn_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int g = 0; g < 3; g++)
            begin
                sn_reg[g] <= rneg[g][STEPS] ? -ry[g][STEPS] : ry[g][STEPS];
                cn_reg[g] <= rneg[g][STEPS] ? -rx[g][STEPS] : rx[g][STEPS];
            end
        end
    end

    // product stages
    logic signed [AW-1:0] nx1_reg, pa_reg, pb_reg, pc_reg, pd_reg, cd_reg;
    logic signed [AW-1:0] nx2_reg, pa2_reg, pc2_reg, pe_reg, pf_reg;
    logic signed [AW-1:0] nx3_reg, ny_reg, den3_reg;
    logic [SQW-1:0]       sqa_reg, sqb_reg;
    logic signed [AW-1:0] den4_reg, den5_reg;
    logic [SQW-1:0]       sum_reg;
    logic [AW-1:0]        ax, ay;
    logic [2*AW-1:0]      sqa_full, sqb_full;

    assign ax       = nx3_reg[AW-1] ? unsigned'(-nx3_reg) : unsigned'(nx3_reg);
    assign ay       = ny_reg[AW-1] ? unsigned'(-ny_reg) : unsigned'(ny_reg);
    assign sqa_full = ax * ax;
    assign sqb_full = ay * ay;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx1_reg  <= gcca_pkg::mulw(sn_reg[1], sn_reg[2]);
            pa_reg   <= gcca_pkg::mulw(sn_reg[0], cn_reg[1]);
            pb_reg   <= gcca_pkg::mulw(cn_reg[0], sn_reg[1]);
            pc_reg   <= gcca_pkg::mulw(cn_reg[0], cn_reg[1]);
            pd_reg   <= gcca_pkg::mulw(sn_reg[0], sn_reg[1]);
            cd_reg   <= cn_reg[2];
            nx2_reg  <= nx1_reg;
            pa2_reg  <= pa_reg;
            pc2_reg  <= pc_reg;
            pe_reg   <= gcca_pkg::mulw(pb_reg, cd_reg);
            pf_reg   <= gcca_pkg::mulw(pd_reg, cd_reg);
            nx3_reg  <= nx2_reg;
            ny_reg   <= pa2_reg - pe_reg;
            den3_reg <= pc2_reg + pf_reg;
            sqa_reg  <= sqa_full[SQW-1:0];
            sqb_reg  <= sqb_full[SQW-1:0];
            den4_reg <= den3_reg;
            sum_reg  <= sqa_reg + sqb_reg;
            den5_reg <= den4_reg;
        end
    end

    // square root chain, denominator rides alongside
    logic [SQW-1:0]       sv   [SQS+1];
    logic [SQW-1:0]       sres [SQS+1];
    logic signed [AW-1:0] den_line [SQS+1];

    assign sv[0]       = sum_reg;
    assign sres[0]     = '0;
    assign den_line[0] = den5_reg;

    for (genvar k = 0; k < SQS; k++)
    begin : g_sqrt
        gcca_sqrt_cell u_cell (
            .clk     (clk),
            .en      (en),
            .step    (5'(k)),
            .v_in    (sv[k]),
            .res_in  (sres[k]),
            .v_out   (sv[k+1]),
            .res_out (sres[k+1])
        );
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_line[k+1] <= den_line[k];
            end
        end
    end

    // stage P: set up the vectoring chain
    logic signed [VW-1:0] root_s, den_s;
    logic signed [VW-1:0] vx [STEPS+1];
    logic signed [VW-1:0] vy [STEPS+1];
    logic signed [AW-1:0] vz [STEPS+1];
    logic signed [VW-1:0] vx0_reg, vy0_reg;
    logic signed [AW-1:0] vz0_reg;
    logic                 degen;

    assign root_s = VW'(sres[SQS][31:0]);
    assign den_s  = VW'(den_line[SQS]);
    assign degen  = (root_s == '0) && (den_s == '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (den_s < 0)
            begin
                vx0_reg <= root_s;
                vy0_reg <= -den_s;
                vz0_reg <= gcca_pkg::HALF_PI_W;
            end
            else
            begin
                vx0_reg <= den_s;
                vy0_reg <= root_s;
                vz0_reg <= '0;
            end
        end
    end

    assign vx[0] = vx0_reg;
    assign vy[0] = vy0_reg;
    assign vz[0] = vz0_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_vec
        gcca_vec_cell u_cell (
            .clk   (clk),
            .en    (en),
            .step  (5'(i)),
            .arc   (gcca_pkg::ARC_TAB[i]),
            .x_in  (vx[i]),
            .y_in  (vy[i]),
            .z_in  (vz[i]),
            .x_out (vx[i+1]),
            .y_out (vy[i+1]),
            .z_out (vz[i+1])
        );
    end

    // stage O: clamp, rescale, clamp again
    localparam int OUT_W_L = gcca_pkg::OUT_W;
    logic signed [AW-1:0] zc;
    logic signed [63:0]   o;
    logic [OUT_W_L-1:0]   o_fin;
    logic [OUT_W_L-1:0]   central_angle_reg;

    always_comb
    begin
        if (vz[STEPS] < 0)
        begin
            zc = '0;
        end
        else if (vz[STEPS] > gcca_pkg::PI_W)
        begin
            zc = gcca_pkg::PI_W;
        end
        else
        begin
            zc = vz[STEPS];
        end
        o = ((64'(zc) <<< gcca_pkg::OUT_LSH) + ((64'sd1 <<< gcca_pkg::OUT_RSH) >>> 1))
            >>> gcca_pkg::OUT_RSH;
        if (o > signed'(gcca_pkg::PIF))
        begin
            o = signed'(gcca_pkg::PIF);
        end
        // identical points and a zero vector both give zero
        if (ctl_line[ST_O-1].zero)
        begin
            o_fin = '0;
        end
        else
        begin
            o_fin = o[OUT_W_L-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            central_angle_reg <= o_fin;
        end
    end

    assign central_angle = central_angle_reg;

    // control line
    always_comb
    begin
        for (int k = 0; k < LAT; k++)
        begin
            if (k == 0)
            begin
                ctl_next[k].valid = in_valid;
                ctl_next[k].zero  = 1'b0;
            end
            else if (k == ST_F)
            begin
                ctl_next[k].valid = ctl_line[k-1].valid;
                ctl_next[k].zero  = (t1_reg == t2_reg) && (dp_reg == '0);
            end
            else if (k == ST_P)
            begin
                ctl_next[k].valid = ctl_line[k-1].valid;
                ctl_next[k].zero  = ctl_line[k-1].zero || degen;
            end
            else
            begin
                ctl_next[k] = ctl_line[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                ctl_line[k] <= '0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                ctl_line[k] <= ctl_next[k];
            end
        end
    end

    a_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (64'(central_angle) <= gcca_pkg::PIF))
        else $error("central angle above pi");

    a_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ctl_line[LAT-1].zero) |-> (central_angle == '0))
        else $error("flagged item not zero");

    a_enter : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> ctl_line[0].valid)
        else $error("accepted item lost at entry");

    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> ($stable(ctl_line[0]) && $stable(ctl_line[ST_P])))
        else $error("pipeline moved while stalled");

endmodule
